// ===== hw/rtl/cfd_pkg.sv =====
package cfd_pkg;

   localparam int unsigned ADDR_W = 3;
   localparam int unsigned DATA_W = 32;

   localparam logic [15:0] CRC_POLY    = 16'h1021;
   localparam logic [7:0]  MIN_LEN     = 8'd2;
   localparam logic [7:0]  START_RESET = 8'h55;
   localparam logic [15:0] SEED_RESET  = 16'hFFFF;

   // register index, taken from paddr[2]
   localparam logic REG_START_BYTE = 1'b0;
   localparam logic REG_CRC_SEED   = 1'b1;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_LEN     = 3'd1,
      PH_PAYLOAD = 3'd2,
      PH_CRC_HI  = 3'd3,
      PH_CRC_LO  = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_GOOD    = 2'd1,
      KIND_BAD_LEN = 2'd2,
      KIND_CRC_ERR = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0]  start_byte;
      logic [15:0] crc_seed;
   } cfg_type;

   // CRC-16 CCITT, MSB first, one byte
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== hw/rtl/cfd_req_if.sv =====
interface cfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== hw/rtl/cfd_rsp_if.sv =====
interface cfd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data_byte;
   logic [7:0] frame_length;
   logic       frame_end;

   modport source (output valid, output kind, output data_byte, output frame_length,
                   output frame_end, input ready);
   modport sink (input valid, input kind, input data_byte, input frame_length,
                 input frame_end, output ready);
endinterface

// ===== hw/rtl/cfd_csr.sv =====
module cfd_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [cfd_pkg::ADDR_W-1:0] paddr,
   input  logic [cfd_pkg::DATA_W-1:0] pwdata,
   output logic [cfd_pkg::DATA_W-1:0] prdata,
   output logic                        pready,
   output cfd_pkg::cfg_type            cfg
);

   cfd_pkg::cfg_type cfg_ff;
   cfd_pkg::cfg_type cfg_in;
   logic             wr_en;
   logic             reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = paddr[2];
   assign wr_en   = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            cfd_pkg::REG_START_BYTE: cfg_in.start_byte = pwdata[7:0];
            cfd_pkg::REG_CRC_SEED:   cfg_in.crc_seed   = pwdata[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte <= cfd_pkg::START_RESET;
         cfg_ff.crc_seed   <= cfd_pkg::SEED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_sel)
         cfd_pkg::REG_START_BYTE: prdata = {24'h0, cfg_ff.start_byte};
         cfd_pkg::REG_CRC_SEED:   prdata = {16'h0, cfg_ff.crc_seed};
         default:                 prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/cfd_core.sv =====
module cfd_core (
   input  logic             clock,
   input  logic             reset,
   input  cfd_pkg::cfg_type cfg,
   cfd_req_if.sink          req_chan,
   cfd_rsp_if.source        rsp_chan
);

   // input stage
   logic       in_valid_ff, in_valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       accept;
   logic       fire;

   // frame state
   cfd_pkg::phase_type phase_ff, phase_in, phase_next;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  seen_ff, seen_in;
   logic [7:0]  crc_hi_ff, crc_hi_in;

   // result stage
   logic              out_valid_ff, out_valid_in;
   cfd_pkg::kind_type kind_ff, kind_in, kind_next;
   logic [7:0]        data_ff, data_in, data_next;
   logic [7:0]        flen_ff, flen_in, flen_next;
   logic              end_ff, end_in, end_next;
   logic              emit;

   logic [15:0] crc_upd;
   logic [7:0]  seen_inc;
   logic [15:0] crc_got;

   assign fire              = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready    = !in_valid_ff || fire;
   assign accept            = req_chan.valid && req_chan.ready;
   assign in_valid_in       = accept || (in_valid_ff && !fire);
   assign byte_in           = accept ? req_chan.rx_byte : byte_ff;

   assign crc_upd  = cfd_pkg::crc_byte(crc_ff, byte_ff);
   assign seen_inc = seen_ff + 8'd1;
   assign crc_got  = {crc_hi_ff, byte_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= cfd_pkg::PH_HUNT;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      crc_ff    <= crc_in;
      len_ff    <= len_in;
      seen_ff   <= seen_in;
      crc_hi_ff <= crc_hi_in;
      kind_ff   <= kind_in;
      data_ff   <= data_in;
      flen_ff   <= flen_in;
      end_ff    <= end_in;
   end

   always_comb begin
      phase_next = cfd_pkg::PH_HUNT;
      crc_in     = crc_ff;
      len_in     = len_ff;
      seen_in    = seen_ff;
      crc_hi_in  = crc_hi_ff;
      emit       = 1'b0;
      kind_next  = cfd_pkg::KIND_PAYLOAD;
      data_next  = 8'h00;
      flen_next  = 8'h00;
      end_next   = 1'b0;

      case (phase_ff)
         cfd_pkg::PH_LEN: begin
            if (byte_ff < cfd_pkg::MIN_LEN) begin
               phase_next = cfd_pkg::PH_HUNT;
               emit       = 1'b1;
               kind_next  = cfd_pkg::KIND_BAD_LEN;
               flen_next  = byte_ff;
               end_next   = 1'b1;
            end else begin
               phase_next = cfd_pkg::PH_PAYLOAD;
               crc_in     = crc_upd;
               len_in     = byte_ff;
               seen_in    = 8'h00;
            end
         end
         cfd_pkg::PH_PAYLOAD: begin
            crc_in     = crc_upd;
            seen_in    = seen_inc;
            phase_next = (seen_inc >= len_ff) ? cfd_pkg::PH_CRC_HI : cfd_pkg::PH_PAYLOAD;
            emit       = 1'b1;
            kind_next  = cfd_pkg::KIND_PAYLOAD;
            data_next  = byte_ff;
         end
         cfd_pkg::PH_CRC_HI: begin
            crc_hi_in  = byte_ff;
            phase_next = cfd_pkg::PH_CRC_LO;
         end
         cfd_pkg::PH_CRC_LO: begin
            phase_next = cfd_pkg::PH_HUNT;
            emit       = 1'b1;
            kind_next  = (crc_got == crc_ff) ? cfd_pkg::KIND_GOOD : cfd_pkg::KIND_CRC_ERR;
            flen_next  = len_ff;
            end_next   = 1'b1;
         end
         default: begin
            // hunting; unused codes land here too
            if (byte_ff == cfg.start_byte) begin
               crc_in     = cfd_pkg::crc_byte(cfg.crc_seed, byte_ff);
               phase_next = cfd_pkg::PH_LEN;
            end
         end
      endcase

      // hold everything unless the byte in the input stage moves on
      if (!fire) begin
         crc_in    = crc_ff;
         len_in    = len_ff;
         seen_in   = seen_ff;
         crc_hi_in = crc_hi_ff;
      end
   end

   assign phase_in     = fire ? phase_next : phase_ff;
   assign out_valid_in = fire ? emit : (out_valid_ff && !rsp_chan.ready);
   assign kind_in      = (fire && emit) ? kind_next : kind_ff;
   assign data_in      = (fire && emit) ? data_next : data_ff;
   assign flen_in      = (fire && emit) ? flen_next : flen_ff;
   assign end_in       = (fire && emit) ? end_next  : end_ff;

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.kind         = kind_ff;
   assign rsp_chan.data_byte    = data_ff;
   assign rsp_chan.frame_length = flen_ff;
   assign rsp_chan.frame_end    = end_ff;

endmodule

// ===== hw/rtl/crc_frame_deframer.sv =====
// Length-prefixed frame deframer with CRC-16 CCITT check. Each received byte enters through
// req_chan; bytes are dropped until one equals the start_byte register, then a length byte
// (2 to 255), that many payload bytes and a big-endian CRC-16 (poly 0x1021, MSB first,
// seeded from crc_seed, covering start, length and payload) are expected. Every payload byte
// comes out on rsp_chan as kind 0 as soon as it is processed; the frame closes with one status
// transaction (kind 1 good, 2 bad length, 3 CRC mismatch) carrying frame_end and frame_length.
// On kind 2 or 3 the consumer discards the frame; the deframer resumes hunting with the next
// byte. The block takes one byte per clock cycle while rsp_chan does not stall; a single
// byte-wide CRC update sits between the input register and the result register. Registers:
// start_byte at address 0, crc_seed at address 4; write them only while no frame is in flight.
module crc_frame_deframer (
   input  logic                        clock,
   input  logic                        reset,
   cfd_req_if.sink                     req_chan,
   cfd_rsp_if.source                   rsp_chan,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [cfd_pkg::ADDR_W-1:0] paddr,
   input  logic [cfd_pkg::DATA_W-1:0] pwdata,
   output logic [cfd_pkg::DATA_W-1:0] prdata,
   output logic                        pready
);

   cfd_pkg::cfg_type cfg;

   cfd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   cfd_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule
